// ===== src/morus640_aead_core_assert.svh =====
// assertion macros for the morus-640 core
`ifndef MORUS640_AEAD_CORE_ASSERT_SVH
`define MORUS640_AEAD_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define M640_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define M640_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define M640_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define M640_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/m640_pkg.sv =====
// ----------------------------------------------------------------------------
// m640_pkg
// shared types, codes and round function of the morus-640 core
// ----------------------------------------------------------------------------
`default_nettype none
package m640_pkg;

  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    FN_INIT = 3'd0, FN_AD = 3'd1, FN_ENC = 3'd2,
    FN_DEC = 3'd3, FN_TAG = 3'd4, FN_VERIFY = 3'd5
  } func_t;

  // classified item handed from front to back
  typedef struct packed {
    func_t       func;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  count;
    logic [63:0] mask_low;
    logic [63:0] mask_high;
  } cmd_t;

  typedef logic [639:0] state_t;

  localparam logic [127:0] InitRow3 = 128'h6279e990_59372215_0d080503_02010100;
  localparam logic [127:0] InitRow4 = 128'hdd28b573_42311120_f12fc26d_55183ddb;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [127:0] get_row(input state_t s, input int r);
    get_row = s[128*r +: 128];
  endfunction

  // rotate a row left by k words (word j takes word j+k)
  function automatic logic [127:0] shift_row(input logic [127:0] x, input int k);
    logic [127:0] y;
    y = '0;
    for (int j = 0; j < 4; j++) y[32*j +: 32] = x[32*((j + k) % 4) +: 32];
    shift_row = y;
  endfunction

  // one full state update with message block m
  function automatic state_t morus_update(input state_t s_in, input logic [127:0] m);
    state_t s;
    logic [127:0] v;
    int rot [5];
    int ws  [5];
    rot = '{5, 31, 7, 22, 13};
    ws  = '{3, 2, 1, 2, 3};
    s = s_in;
    for (int r = 0; r < 5; r++) begin
      v = get_row(s, r) ^ get_row(s, (r + 3) % 5)
        ^ (get_row(s, (r + 1) % 5) & get_row(s, (r + 2) % 5));
      if (r > 0) v = v ^ m;
      for (int j = 0; j < 4; j++) s[128*r + 32*j +: 32] = rotl(v[32*j +: 32], rot[r]);
      s[128*((r + 3) % 5) +: 128] = shift_row(get_row(s, (r + 3) % 5), ws[r]);
    end
    morus_update = s;
  endfunction

  function automatic logic [127:0] keystream(input state_t s);
    keystream = get_row(s, 0) ^ shift_row(get_row(s, 1), 1)
              ^ (get_row(s, 2) & get_row(s, 3));
  endfunction

endpackage
`default_nettype wire

// ===== src/m640_front.sv =====
// ----------------------------------------------------------------------------
// m640_front
// accepts items, drops ignored ones, builds byte masks, queues commands
// ----------------------------------------------------------------------------
`default_nettype none
module m640_front #(
  parameter int DEPTH = m640_pkg::QueueDepth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [2:0]      func,
  input  wire logic [63:0]     data_low,
  input  wire logic [63:0]     data_high,
  input  wire logic [4:0]      byte_count,
  output logic                 cmd_valid,
  output m640_pkg::cmd_t       cmd,
  input  wire logic            cmd_take
);
  import m640_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t q_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic [4:0] n;
  logic keep, wr;
  cmd_t c;

  // classify and build masks
  always_comb begin
    n = (byte_count > 5'd16) ? 5'd16 : byte_count;
    c.func = func_t'(func);
    c.data_low = data_low;
    c.data_high = data_high;
    c.count = n;
    for (int b = 0; b < 8; b++) begin
      c.mask_low[8*b +: 8]  = (n > 5'(b)) ? 8'hff : 8'h00;
      c.mask_high[8*b +: 8] = (n > 5'(b + 8)) ? 8'hff : 8'h00;
    end
    unique case (func)
      FN_INIT, FN_TAG, FN_VERIFY: keep = 1'b1;
      FN_AD, FN_ENC, FN_DEC: keep = (n != 5'd0);
      default: keep = 1'b0;
    endcase
  end

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign wr = push && !full && keep;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  // pointers
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (wr) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (cmd_take) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(wr) - (AW+1)'(cmd_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= c;
  end
endmodule
`default_nettype wire

// ===== src/m640_back.sv =====
// ----------------------------------------------------------------------------
// m640_back
// cipher state, one update per cycle unless stalled by a full result register, result register
// ----------------------------------------------------------------------------
`default_nettype none
module m640_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [63:0]     key_low,
  input  wire logic [63:0]     key_high,
  input  wire logic            cmd_valid,
  input  wire m640_pkg::cmd_t  cmd,
  output logic                 cmd_take,
  output logic                 empty,
  input  wire logic            pop,
  output logic [63:0]          out_low,
  output logic [63:0]          out_high,
  output logic [4:0]           out_count,
  output logic                 tag_match
);
  import m640_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_INIT = 3'b010, ST_FIN = 3'b100
  } st_t;

  st_t st_r, st_nxt;
  state_t s_r, s_nxt, s_upd;
  logic [63:0] adl_r, adl_nxt, msl_r, msl_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [127:0] upd_m, ks, blk, res, key, tag, cur_data;
  logic cur_verify_r, cur_verify_nxt;
  logic [127:0] exp_r, exp_nxt;
  logic full_out, ld;
  logic [63:0] ol_nxt, oh_nxt;
  logic [4:0] oc_nxt;
  logic tm_nxt;

  assign key = {key_high, key_low};
  assign full_out = !empty;
  assign s_upd = morus_update(s_r, upd_m);
  assign ks = keystream(s_r);
  assign blk = {cmd.data_high & cmd.mask_high, cmd.data_low & cmd.mask_low};
  assign res = (blk ^ ks) & {cmd.mask_high, cmd.mask_low};
  assign tag = get_row(s_upd, 0) ^ shift_row(get_row(s_upd, 1), 1)
             ^ (get_row(s_upd, 2) & get_row(s_upd, 3));
  assign cur_data = {cmd.data_high, cmd.data_low};

  // sequencer and state update
  always_comb begin
    st_nxt = st_r;
    s_nxt = s_r;
    adl_nxt = adl_r;
    msl_nxt = msl_r;
    rnd_nxt = rnd_r;
    cur_verify_nxt = cur_verify_r;
    exp_nxt = exp_r;
    upd_m = '0;
    cmd_take = 1'b0;
    ld = 1'b0;
    ol_nxt = '0;
    oh_nxt = '0;
    oc_nxt = '0;
    tm_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.func)
            FN_INIT: begin
              cmd_take = 1'b1;
              s_nxt = {InitRow4, InitRow3, {128{1'b1}}, key, cur_data};
              rnd_nxt = '0;
              adl_nxt = '0;
              msl_nxt = '0;
              st_nxt = ST_INIT;
            end
            FN_AD: begin
              cmd_take = 1'b1;
              upd_m = blk;
              s_nxt = s_upd;
              adl_nxt = adl_r + 64'(cmd.count);
            end
            FN_ENC, FN_DEC: begin
              if (!full_out || pop) begin
                cmd_take = 1'b1;
                upd_m = (cmd.func == FN_ENC) ? blk : res;
                s_nxt = s_upd;
                msl_nxt = msl_r + 64'(cmd.count);
                ld = 1'b1;
                ol_nxt = res[63:0];
                oh_nxt = res[127:64];
                oc_nxt = cmd.count;
              end
            end
            FN_TAG, FN_VERIFY: begin
              cmd_take = 1'b1;
              cur_verify_nxt = (cmd.func == FN_VERIFY);
              exp_nxt = cur_data;
              s_nxt[512 +: 128] = get_row(s_r, 4) ^ get_row(s_r, 0);
              rnd_nxt = '0;
              st_nxt = ST_FIN;
            end
            default: cmd_take = 1'b1;
          endcase
        end
      end
      ST_INIT: begin
        s_nxt = s_upd;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == 4'd15) begin
          s_nxt[128 +: 128] = get_row(s_upd, 1) ^ key;
          st_nxt = ST_IDLE;
        end
      end
      ST_FIN: begin
        upd_m = {msl_r << 3, adl_r << 3};
        if (rnd_r != 4'd9) begin
          s_nxt = s_upd;
          rnd_nxt = rnd_r + 1'b1;
        end else if (!full_out || pop) begin
          s_nxt = s_upd;
          s_nxt[0 +: 128] = tag;
          ld = 1'b1;
          if (cur_verify_r) tm_nxt = (tag == exp_r);
          else begin
            ol_nxt = tag[63:0];
            oh_nxt = tag[127:64];
            oc_nxt = 5'd16;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      s_r <= '0;
      adl_r <= '0;
      msl_r <= '0;
      rnd_r <= '0;
      empty <= 1'b1;
    end else begin
      st_r <= st_nxt;
      s_r <= s_nxt;
      adl_r <= adl_nxt;
      msl_r <= msl_nxt;
      rnd_r <= rnd_nxt;
      if (ld) empty <= 1'b0;
      else if (pop) empty <= 1'b1;
    end
  end

  // result register and finalize operands
  always_ff @(posedge clk) begin
    cur_verify_r <= cur_verify_nxt;
    exp_r <= exp_nxt;
    if (ld) begin
      out_low <= ol_nxt;
      out_high <= oh_nxt;
      out_count <= oc_nxt;
      tag_match <= tm_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/morus640_aead_core.sv =====
// ----------------------------------------------------------------------------
// morus640_aead_core
// morus-640 authenticated cipher core: command queue front, cipher back
// ----------------------------------------------------------------------------
// channel   ports                                      handshake
// input     in_func in_data_low/high in_byte_count     push / full
// result    out_low out_high out_count out_tag_match   empty / pop
// config    cfg_we cfg_index cfg_data                  write enable
//
// ad, encrypt and decrypt items each take one state update
// init and make/verify tag run their rounds in the round sequencer
// the front queue holds QUEUE_DEPTH items (two by default), so input accepts while the back works
// a full result register stalls encrypt, decrypt and finalize
// reset clears the state, lengths, key and queue
`default_nettype none
module morus640_aead_core #(
  parameter int QUEUE_DEPTH = m640_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  in_func,
  input  wire logic [63:0] in_data_low,
  input  wire logic [63:0] in_data_high,
  input  wire logic [4:0]  in_byte_count,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      out_low,
  output logic [63:0]      out_high,
  output logic [4:0]       out_count,
  output logic             out_tag_match,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);
  import m640_pkg::*;
  `include "morus640_aead_core_assert.svh"

  logic [63:0] key_low_r, key_high_r;
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index) key_high_r <= cfg_data;
      else key_low_r <= cfg_data;
    end
  end

  m640_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .push, .full,
    .func(in_func), .data_low(in_data_low), .data_high(in_data_high),
    .byte_count(in_byte_count), .cmd_valid, .cmd, .cmd_take
  );

  m640_back u_back (
    .clk, .rst_n, .key_low(key_low_r), .key_high(key_high_r),
    .cmd_valid, .cmd, .cmd_take, .empty, .pop,
    .out_low, .out_high, .out_count, .tag_match(out_tag_match)
  );

  // checks
  `M640_ASSERT_IMP(a_take_valid, clk, rst_n, cmd_take, cmd_valid)
  `M640_ASSERT_IMP(a_empty_clean, clk, rst_n, !empty && out_tag_match, out_count == 5'd0)
  `M640_ASSERT_NXT(a_hold_result, clk, rst_n, !empty && !pop, !empty && $stable(out_low))
endmodule
`default_nettype wire
